[hw/rtl/elgsv_pkg.sv]
// Shared constants for the ElGamal signature verifier.
// Holds field widths and register indexes; no dependencies.
`default_nettype none

package elgsv_pkg;

   localparam int FIELD_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GENERATOR    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PUBLIC_VALUE = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/elgamal_signature_verify_top.sv]
// Top level of the ElGamal signature verifier: key registers, sequencer, result register.
// Depends on elgsv_pkg and elgsv_mulmod.
`default_nettype none

// Checks q^x * x^y == g^m (mod p) for each request beat, with p, g, q taken from
// the configuration registers, and answers with one response beat holding 1 on a
// match. One request is worked at a time. The bases are first reduced mod p,
// one bit per cycle over all max(16, MOD_WIDTH) bits. Then three powers run by
// right-to-left square-and-multiply on one shared bit-serial multiplier, and one
// product joins the first two. A multiply ends early when its multiplier has
// leading zeros. Each exponent bit passes a test state and then, for a set bit,
// a multiply, then a square. Short exponents or a small modulus shorten a
// request; a modulus below two skips the work and answers 0.
module elgamal_signature_verify_top #(
   parameter int MOD_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [elgsv_pkg::FIELD_WIDTH-1:0]      req_message,
   input  wire logic [elgsv_pkg::FIELD_WIDTH-1:0]      req_sig_first,
   input  wire logic [elgsv_pkg::FIELD_WIDTH-1:0]      req_sig_second,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_valid_res,
   input  wire logic                                   csr_we,
   input  wire logic [elgsv_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [elgsv_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int FW    = elgsv_pkg::FIELD_WIDTH;
   localparam int RW    = (MOD_WIDTH > FW) ? MOD_WIDTH : FW;
   localparam int CNT_W = $clog2(RW);
   localparam int CW    = (MOD_WIDTH < elgsv_pkg::CSR_DATA_WIDTH) ?
                          MOD_WIDTH : elgsv_pkg::CSR_DATA_WIDTH;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_LOAD,
      S_POW_TEST,
      S_POW_MUL,
      S_POW_SQR,
      S_LHS_MUL,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      POW_QX,
      POW_XY,
      POW_GM
   } pow_sel_type;

   state_type            state_ff;
   pow_sel_type          pow_ff;

   logic [MOD_WIDTH-1:0] mod_ff, gen_ff, pub_ff;
   logic [FW-1:0]        msg_ff, x_ff, y_ff;
   logic [RW-1:0]        shg_ff, shq_ff, shx_ff;
   logic [MOD_WIDTH-1:0] rg_ff, rq_ff, rx_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [MOD_WIDTH-1:0] base_ff, acc_ff, r1_ff, lhs_ff;
   logic [FW-1:0]        exp_ff;
   logic                 res_ff;
   logic                 rsp_valid_ff, rsp_res_ff;

   logic                 mul_start;
   logic [MOD_WIDTH-1:0] mul_a, mul_b;
   logic                 mul_done;
   logic [MOD_WIDTH-1:0] mul_product;

   logic [CW-1:0]        csr_field;
   logic                 req_take;

   // one step of MSB-first reduction: r = (2r + bit) mod n
   function automatic logic [MOD_WIDTH-1:0] reduce_step(
      input logic [MOD_WIDTH-1:0] r,
      input logic                 bit_in,
      input logic [MOD_WIDTH-1:0] n
   );
      logic [MOD_WIDTH:0] t;
      logic [MOD_WIDTH:0] d;
      begin
         t = {r, bit_in};
         d = t - {1'b0, n};
         if (t >= {1'b0, n}) begin
            return d[MOD_WIDTH-1:0];
         end
         return t[MOD_WIDTH-1:0];
      end
   endfunction

   assign csr_field = csr_wdata[CW-1:0];
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // operand select for the shared multiplier
   always_comb begin
      mul_start = 1'b0;
      mul_a     = acc_ff;
      mul_b     = base_ff;
      unique case (state_ff)
         S_POW_TEST: begin
            if (exp_ff != '0) begin
               mul_start = 1'b1;
               if (!exp_ff[0]) begin
                  mul_a = base_ff;
               end
            end else if (pow_ff == POW_XY) begin
               mul_start = 1'b1;
               mul_a     = r1_ff;
               mul_b     = acc_ff;
            end
         end
         S_POW_MUL: begin
            mul_a = base_ff;
            if (mul_done) begin
               mul_start = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   elgsv_mulmod #(
      .MOD_WIDTH(MOD_WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .n       (mod_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_WIDTH'(11);
         gen_ff <= MOD_WIDTH'(2);
         pub_ff <= MOD_WIDTH'(9);
      end else if (csr_we) begin
         unique case (csr_index)
            elgsv_pkg::CSR_MODULUS:      mod_ff <= MOD_WIDTH'(csr_field);
            elgsv_pkg::CSR_GENERATOR:    gen_ff <= MOD_WIDTH'(csr_field);
            elgsv_pkg::CSR_PUBLIC_VALUE: pub_ff <= MOD_WIDTH'(csr_field);
            default: begin
            end
         endcase
      end
   end

   // sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pow_ff       <= POW_QX;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the done state refills the slot itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  msg_ff <= req_message;
                  x_ff   <= req_sig_first;
                  y_ff   <= req_sig_second;
                  shg_ff <= RW'(gen_ff);
                  shq_ff <= RW'(pub_ff);
                  shx_ff <= RW'(req_sig_first);
                  rg_ff  <= '0;
                  rq_ff  <= '0;
                  rx_ff  <= '0;
                  cnt_ff <= '0;
                  if (mod_ff < MOD_WIDTH'(2)) begin
                     res_ff   <= 1'b0;
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_REDUCE;
                  end
               end
            end
            S_REDUCE: begin
               rg_ff  <= reduce_step(rg_ff, shg_ff[RW-1], mod_ff);
               rq_ff  <= reduce_step(rq_ff, shq_ff[RW-1], mod_ff);
               rx_ff  <= reduce_step(rx_ff, shx_ff[RW-1], mod_ff);
               shg_ff <= shg_ff << 1;
               shq_ff <= shq_ff << 1;
               shx_ff <= shx_ff << 1;
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(RW - 1)) begin
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               base_ff  <= rq_ff;
               exp_ff   <= x_ff;
               acc_ff   <= MOD_WIDTH'(1);
               pow_ff   <= POW_QX;
               state_ff <= S_POW_TEST;
            end
            S_POW_TEST: begin
               if (exp_ff != '0) begin
                  state_ff <= exp_ff[0] ? S_POW_MUL : S_POW_SQR;
               end else begin
                  unique case (pow_ff)
                     POW_QX: begin
                        r1_ff   <= acc_ff;
                        base_ff <= rx_ff;
                        exp_ff  <= y_ff;
                        acc_ff  <= MOD_WIDTH'(1);
                        pow_ff  <= POW_XY;
                     end
                     POW_XY: begin
                        state_ff <= S_LHS_MUL;
                     end
                     default: begin
                        res_ff   <= (lhs_ff == acc_ff);
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_POW_MUL: begin
               // square starts in the same cycle
               if (mul_done) begin
                  acc_ff   <= mul_product;
                  state_ff <= S_POW_SQR;
               end
            end
            S_POW_SQR: begin
               if (mul_done) begin
                  base_ff  <= mul_product;
                  exp_ff   <= exp_ff >> 1;
                  state_ff <= S_POW_TEST;
               end
            end
            S_LHS_MUL: begin
               if (mul_done) begin
                  lhs_ff   <= mul_product;
                  base_ff  <= rg_ff;
                  exp_ff   <= msg_ff;
                  acc_ff   <= MOD_WIDTH'(1);
                  pow_ff   <= POW_GM;
                  state_ff <= S_POW_TEST;
               end
            end
            S_DONE: begin
               // hold until the response slot frees up
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_res_ff   <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

endmodule

`default_nettype wire

[hw/rtl/elgsv_mulmod.sv]
// Bit-serial modular multiplier: shift-and-add, one multiplier bit per cycle.
// Standalone; operands must be below the modulus, and the user must hold the modulus while busy (not enforced here).
`default_nettype none

module elgsv_mulmod #(
   parameter int MOD_WIDTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [MOD_WIDTH-1:0] a,
   input  wire logic [MOD_WIDTH-1:0] b,
   input  wire logic [MOD_WIDTH-1:0] n,
   output logic                      done,
   output logic [MOD_WIDTH-1:0]      product
);

   logic                 busy_ff, busy_in;
   logic [MOD_WIDTH-1:0] a_ff, a_in;
   logic [MOD_WIDTH-1:0] b_ff, b_in;
   logic [MOD_WIDTH-1:0] acc_ff, acc_in;

   // (x + y) mod n for x, y < n
   function automatic logic [MOD_WIDTH-1:0] add_mod(
      input logic [MOD_WIDTH-1:0] x,
      input logic [MOD_WIDTH-1:0] y,
      input logic [MOD_WIDTH-1:0] m
   );
      logic [MOD_WIDTH:0] s;
      logic [MOD_WIDTH:0] d;
      begin
         s = {1'b0, x} + {1'b0, y};
         d = s - {1'b0, m};
         if (s >= {1'b0, m}) begin
            return d[MOD_WIDTH-1:0];
         end
         return s[MOD_WIDTH-1:0];
      end
   endfunction

   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (b_ff[0]) begin
               acc_in = add_mod(acc_ff, a_ff, n);
            end
            a_in = add_mod(a_ff, a_ff, n);
            b_in = b_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   // finished once the multiplier bits run out
   assign done    = busy_ff && (b_ff == '0);
   assign product = acc_ff;

endmodule

`default_nettype wire

[sim/elgamal_signature_verify_top_tb.sv]
// Self-checking testbench for elgamal_signature_verify_top.
// Depends on elgsv_pkg and the verifier RTL; predicts each verdict and checks every response beat.
`default_nettype none

module elgamal_signature_verify_top_tb;

   localparam int W                = elgsv_pkg::FIELD_WIDTH;
   localparam int CLK_PERIOD       = 4;
   localparam int RESET_CYCLES     = 4;
   localparam int CYCLE_LIMIT      = 4_000_000;
   localparam int LONG_HOLD_CYCLES = 6000;
   localparam int DRAIN_CYCLES     = 2000;
   localparam int RANDOM_PHASES    = 9;
   localparam int ITEMS_PER_PHASE  = 38;
   localparam logic [W-1:0] FIELD_MAX     = {W{1'b1}};
   localparam logic [W-1:0] BIG_PRIME     = 16'd65521;
   localparam logic [elgsv_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [W-1:0] message;
      logic [W-1:0] sig_first;
      logic [W-1:0] sig_second;
   } sig_item_type;

   typedef struct {
      sig_item_type item;
      bit           verdict;
   } verdict_type;

   logic                                  clock          = 1'b0;
   logic                                  reset          = 1'b1;
   logic                                  req_valid      = 1'b0;
   logic                                  req_stall;
   logic [W-1:0]                          req_message    = '0;
   logic [W-1:0]                          req_sig_first  = '0;
   logic [W-1:0]                          req_sig_second = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall      = 1'b0;
   logic                                  rsp_valid_res;
   logic                                  csr_we         = 1'b0;
   logic [elgsv_pkg::CSR_INDEX_WIDTH-1:0] csr_index      = '0;
   logic [elgsv_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata      = '0;

   // public key as the block should hold it
   logic [W-1:0] key_modulus   = 16'd11;
   logic [W-1:0] key_generator = 16'd2;
   logic [W-1:0] key_public    = 16'd9;

   sig_item_type pending_items[$];
   verdict_type  verdicts_due[$];

   int mismatches  = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int holds_asked = 0;
   int holds_done  = 0;
   int hold_left   = 0;

   elgamal_signature_verify_top #(
      .MOD_WIDTH(W)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_message   (req_message),
      .req_sig_first (req_sig_first),
      .req_sig_second(req_sig_second),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_valid_res (rsp_valid_res),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [W-1:0] mul_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input logic [W-1:0] n);
      logic [2*W-1:0] prod;
      prod = {{W{1'b0}}, a} * {{W{1'b0}}, b};
      return W'(prod % n);
   endfunction

   function automatic logic [W-1:0] pow_mod(input logic [W-1:0] base, input logic [W-1:0] e,
                                            input logic [W-1:0] n);
      logic [W-1:0] acc;
      logic [W-1:0] sq;
      acc = 1;
      sq  = base % n;
      for (int i = 0; i < W; i++) begin
         if (e[i])
            acc = mul_mod(acc, sq, n);
         sq = mul_mod(sq, sq, n);
      end
      return acc;
   endfunction

   // q^x * x^y against g^m under the current key
   function automatic bit signature_holds(input sig_item_type it);
      logic [W-1:0] lhs;
      logic [W-1:0] rhs;
      if (key_modulus < 2)
         return 1'b0;
      lhs = mul_mod(pow_mod(key_public, it.sig_first, key_modulus),
                    pow_mod(it.sig_first, it.sig_second, key_modulus), key_modulus);
      rhs = pow_mod(key_generator, it.message, key_modulus);
      return lhs == rhs;
   endfunction

   // Sign with nonce k: x = g^k (+ multiples of p), m = a*x + k*y mod (p-1) (+ multiples).
   function automatic sig_item_type sign_message(input logic [W-1:0] p, input logic [W-1:0] g,
                                                 input int unsigned secret, input bit corrupt);
      sig_item_type    it;
      longint unsigned pl;
      longint unsigned k;
      longint unsigned x;
      longint unsigned e;
      longint unsigned span;
      int              flip;
      pl   = p;
      k    = $urandom_range(p - 1, 1);
      x    = pow_mod(g, k[W-1:0], p);
      span = (FIELD_MAX - x) / pl;
      x    = x + pl * $urandom_range(32'(span), 0);
      it.sig_first  = x[W-1:0];
      it.sig_second = W'($urandom_range(FIELD_MAX, 0));
      e    = (secret * x + k * it.sig_second) % (pl - 1);
      span = (FIELD_MAX - e) / (pl - 1);
      e    = e + (pl - 1) * $urandom_range(32'(span), 0);
      it.message = e[W-1:0];
      if (corrupt) begin
         flip = $urandom_range(W - 1, 0);
         it.message[flip] = ~it.message[flip];
      end
      return it;
   endfunction

   function automatic logic [W-1:0] pick_prime();
      case ($urandom_range(9, 0))
         0: return 16'd2;
         1: return 16'd3;
         2: return 16'd5;
         3: return 16'd7;
         4: return 16'd11;
         5: return 16'd13;
         6: return 16'd251;
         7: return 16'd257;
         8: return 16'd7919;
         default: return BIG_PRIME;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic write_reg(input logic [elgsv_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [elgsv_pkg::CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         elgsv_pkg::CSR_MODULUS:      key_modulus   = value;
         elgsv_pkg::CSR_GENERATOR:    key_generator = value;
         elgsv_pkg::CSR_PUBLIC_VALUE: key_public    = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_key(input logic [W-1:0] p, input logic [W-1:0] g, input logic [W-1:0] q);
      write_reg(elgsv_pkg::CSR_MODULUS, p);
      write_reg(elgsv_pkg::CSR_GENERATOR, g);
      write_reg(elgsv_pkg::CSR_PUBLIC_VALUE, q);
   endtask

   task automatic offer(input logic [W-1:0] m, input logic [W-1:0] x, input logic [W-1:0] y);
      sig_item_type it;
      it.message    = m;
      it.sig_first  = x;
      it.sig_second = y;
      pending_items.push_back(it);
   endtask

   // hold until every beat is sent and every verdict is back
   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_items.size() != 0 || req_valid || verdicts_due.size() != 0);
   endtask

   task automatic set_idling(input int tx_pct, input int rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
   endtask

   task automatic choose_key(output logic [W-1:0] p, output logic [W-1:0] g,
                             output logic [W-1:0] q, output int unsigned secret,
                             output bit signable);
      int unsigned q0;
      if ($urandom_range(99, 0) < 80) begin
         p = pick_prime();
         do
            g = W'($urandom);
         while (g % p == 0);
         secret   = $urandom_range(FIELD_MAX, 0);
         q0       = pow_mod(g, secret[W-1:0], p);
         q0       = q0 + p * $urandom_range((FIELD_MAX - q0) / p, 0);
         q        = q0[W-1:0];
         signable = 1'b1;
      end else begin
         p        = W'($urandom);
         g        = W'($urandom);
         q        = W'($urandom);
         secret   = 0;
         signable = 1'b0;
      end
   endtask

   task automatic queue_random_items(input int count, input bit signable, input logic [W-1:0] p,
                                     input logic [W-1:0] g, input int unsigned secret);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99, 0);
         if (signable && pick < 45)
            pending_items.push_back(sign_message(p, g, secret, 1'b0));
         else if (signable && pick < 75)
            pending_items.push_back(sign_message(p, g, secret, 1'b1));
         else
            offer(W'($urandom), W'($urandom), W'($urandom));
      end
   endtask

   // request driver
   always @(posedge clock) begin
      sig_item_type next_item;
      verdict_type  due;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due.item    = '{req_message, req_sig_first, req_sig_second};
            due.verdict = signature_holds(due.item);
            verdicts_due.push_back(due);
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
               next_item      = pending_items.pop_front();
               req_message    <= next_item.message;
               req_sig_first  <= next_item.sig_first;
               req_sig_second <= next_item.sig_second;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response stall: random, or a long hold when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_stall  <= 1'b1;
         hold_left  <= LONG_HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < rx_idle_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      verdict_type due;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            report_mismatch("response beat with no request outstanding");
         end else begin
            due = verdicts_due.pop_front();
            if (rsp_valid_res !== due.verdict)
               report_mismatch($sformatf("m=%h x=%h y=%h: valid_res %b, expected %b",
                  due.item.message, due.item.sig_first, due.item.sig_second,
                  rsp_valid_res, due.verdict));
         end
      end
   end

   initial begin
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
         @(posedge clock);
      $display("[elgamal_signature_verify_top] ERROR");
      $finish;
   end

   initial begin
      logic [W-1:0] p;
      logic [W-1:0] g;
      logic [W-1:0] q;
      int unsigned  secret;
      bit           signable;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_idling(25, 83);
      @(negedge clock);

      // reset key: p = 11, g = 2, q = 9 = 2^6
      offer(0, 0, 0);
      offer(FIELD_MAX, FIELD_MAX, FIELD_MAX);
      offer(0, FIELD_MAX, 0);
      offer(FIELD_MAX, 0, FIELD_MAX);
      offer(0, 0, FIELD_MAX);
      offer(3, 55, 3);
      repeat (3) pending_items.push_back(sign_message(16'd11, 16'd2, 6, 1'b0));
      pending_items.push_back(sign_message(16'd11, 16'd2, 6, 1'b1));
      wait_drained();

      // modulus below two answers 0
      write_reg(elgsv_pkg::CSR_MODULUS, 16'd0);
      @(negedge clock);
      offer(0, 0, 0);
      offer(FIELD_MAX, FIELD_MAX, FIELD_MAX);
      wait_drained();
      write_reg(elgsv_pkg::CSR_MODULUS, 16'd1);
      @(negedge clock);
      offer(0, 0, 0);
      offer(1, 1, 1);
      wait_drained();

      load_key(FIELD_MAX, FIELD_MAX, FIELD_MAX);
      @(negedge clock);
      offer(0, 0, 0);
      offer(FIELD_MAX, FIELD_MAX, FIELD_MAX);
      offer(1, FIELD_MAX, 0);
      offer(FIELD_MAX, 1, 1);
      offer(W'($urandom), W'($urandom), W'($urandom));
      wait_drained();

      // zero bases; the spare index must not touch the key
      load_key(BIG_PRIME, 0, 0);
      write_reg(CSR_SPARE, 16'd1);
      @(negedge clock);
      offer(0, 0, 0);
      offer(1, 0, 0);
      offer(0, 1, 0);
      offer(5, 3, 2);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 3)
            set_idling(83, 25);
         else if (ph == 6)
            set_idling(0, 0);
         choose_key(p, g, q, secret, signable);
         load_key(p, g, q);
         @(negedge clock);
         if (ph == 1)
            holds_asked++;
         if (ph == 4) begin
            queue_random_items(ITEMS_PER_PHASE / 2, signable, p, g, secret);
            wait_drained();
            queue_random_items(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2, signable, p, g, secret);
         end else begin
            queue_random_items(ITEMS_PER_PHASE, signable, p, g, secret);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[elgamal_signature_verify_top] OK");
      else
         $display("[elgamal_signature_verify_top] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/elgsv_pkg.sv
hw/rtl/elgsv_mulmod.sv
hw/rtl/elgamal_signature_verify_top.sv
sim/elgamal_signature_verify_top_tb.sv
